>>> rtl/udsrc_pkg.sv
package udsrc_pkg;

	// saturation limit of the pending step count
	localparam int MAX_PENDING = 127;

	localparam int AMOUNT_W  = 7;
	localparam int PENDING_W = 7;
	localparam int VOLUME_W  = 8;

	typedef logic [1:0] mode_t;

	localparam mode_t MODE_INC  = 2'd0;
	localparam mode_t MODE_DEC  = 2'd1;
	localparam mode_t MODE_TICK = 2'd2;

	typedef enum logic [2:0] {
		DIR_IDLE = 3'b001,
		DIR_UP   = 3'b010,
		DIR_DOWN = 3'b100
	} dir_t;

	typedef struct packed {
		logic signed [VOLUME_W-1:0] volume_count;
		logic [PENDING_W-1:0]       pending_steps;
		logic                       moving;
		logic                       up_down;
		logic                       chip_select_n;
		logic                       reversed;
	} result_t;

	function automatic logic [PENDING_W-1:0] sat_pending(input logic [PENDING_W:0] v);
		if (v > (PENDING_W+1)'(MAX_PENDING)) begin
			return PENDING_W'(MAX_PENDING);
		end
		return v[PENDING_W-1:0];
	endfunction

endpackage

>>> rtl/udsrc_in_stage.sv
module udsrc_in_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  udsrc_pkg::mode_t              mode,
	input  logic [udsrc_pkg::AMOUNT_W-1:0] amount,
	input  logic                          take,
	output logic                          valid_s1,
	output udsrc_pkg::mode_t              mode_s1,
	output logic [udsrc_pkg::AMOUNT_W-1:0] amount_s1
);
	import udsrc_pkg::*;

	// free slot, or the held word leaves this cycle
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1   <= mode;
			amount_s1 <= amount;
		end
	end

endmodule

>>> rtl/udsrc_step_logic.sv
module udsrc_step_logic (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          commit,
	input  udsrc_pkg::mode_t              mode_s1,
	input  logic [udsrc_pkg::AMOUNT_W-1:0] amount_s1,
	output udsrc_pkg::result_t            result
);
	import udsrc_pkg::*;

	logic [VOLUME_W-1:0]  volume_q, volume_d;
	logic [PENDING_W-1:0] pending_q, pending_d;
	dir_t                 dir_q, dir_d;
	logic                 rev;

	always_comb begin
		dir_t                 want;
		logic [PENDING_W:0]   amt_x;
		logic [PENDING_W:0]   pend_x;
		logic [PENDING_W-1:0] pend_dec;

		want     = (mode_s1 == MODE_INC) ? DIR_UP : DIR_DOWN;
		amt_x    = {1'b0, amount_s1};
		pend_x   = {1'b0, pending_q};
		pend_dec = (pending_q != '0) ? pending_q - PENDING_W'(1) : pending_q;
		volume_d  = volume_q;
		pending_d = pending_q;
		dir_d     = dir_q;
		rev       = 1'b0;

		case (mode_s1) inside
			MODE_INC, MODE_DEC: begin
				if (dir_q == DIR_IDLE) begin
					// zero amount while idle is dropped
					if (amount_s1 != '0) begin
						pending_d = sat_pending(amt_x);
						dir_d     = want;
					end
				end else if (dir_q == want) begin
					pending_d = sat_pending(pend_x + amt_x);
				end else if (pend_x > amt_x) begin
					pending_d = PENDING_W'(pend_x - amt_x);
				end else if (pend_x == amt_x) begin
					pending_d = '0;
					dir_d     = DIR_IDLE;
				end else begin
					// overshoot: turn around with the remainder
					pending_d = sat_pending(amt_x - pend_x);
					dir_d     = want;
					rev       = 1'b1;
				end
			end
			MODE_TICK: begin
				if (dir_q != DIR_IDLE) begin
					volume_d  = (dir_q == DIR_UP) ? volume_q + VOLUME_W'(1)
					                              : volume_q - VOLUME_W'(1);
					pending_d = pend_dec;
					if (pend_dec == '0) begin
						dir_d = DIR_IDLE;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_q  <= '0;
			pending_q <= '0;
			dir_q     <= DIR_IDLE;
		end else if (commit) begin
			volume_q  <= volume_d;
			pending_q <= pending_d;
			dir_q     <= dir_d;
		end
	end

	always_comb begin
		result.volume_count  = signed'(volume_d);
		result.pending_steps = pending_d;
		result.moving        = (dir_d != DIR_IDLE);
		result.up_down       = (dir_d == DIR_UP);
		result.chip_select_n = (dir_d == DIR_IDLE);
		result.reversed      = rev;
	end

endmodule

>>> rtl/updown_step_request_controller.sv
// channel   handshake             payload
// in        in_valid / in_ready   mode, amount
// out       out_valid / out_ready volume_count, pending_steps, moving, up_down,
//                                 chip_select_n, reversed
//
// an accepted word passes through the input register and then the result
// register on its way to its result word
// one word per cycle when not stalled; the step update is a single add/compare
// on the 7-bit pending count, done as the word moves to the result register
// arst_n clears volume, pending count and direction (idle) and empties
// both registers
// a stalled output holds the result and the input register, then in_ready drops
module updown_step_request_controller (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  udsrc_pkg::mode_t                    mode,
	input  logic [udsrc_pkg::AMOUNT_W-1:0]       amount,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [udsrc_pkg::VOLUME_W-1:0] volume_count,
	output logic [udsrc_pkg::PENDING_W-1:0]      pending_steps,
	output logic                                moving,
	output logic                                up_down,
	output logic                                chip_select_n,
	output logic                                reversed
);
	import udsrc_pkg::*;

	logic                valid_s1;
	mode_t               mode_s1;
	logic [AMOUNT_W-1:0] amount_s1;
	logic                advance;
	result_t             result;
	result_t             result_s2;

	// word moves on when the result register is empty or being drained
	assign advance = valid_s1 && (!out_valid || out_ready);

	udsrc_in_stage u_in_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.amount    (amount),
		.take      (advance),
		.valid_s1  (valid_s1),
		.mode_s1   (mode_s1),
		.amount_s1 (amount_s1)
	);

	// state commits together with the result capture
	udsrc_step_logic u_step_logic (
		.clk       (clk),
		.arst_n    (arst_n),
		.commit    (advance),
		.mode_s1   (mode_s1),
		.amount_s1 (amount_s1),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign volume_count  = result_s2.volume_count;
	assign pending_steps = result_s2.pending_steps;
	assign moving        = result_s2.moving;
	assign up_down       = result_s2.up_down;
	assign chip_select_n = result_s2.chip_select_n;
	assign reversed      = result_s2.reversed;

endmodule
